// ===== hdl/det_pkg.sv =====
package det_pkg;

    localparam int EDGE_MAX = 64;
    localparam int NODE_MAX = 64;

    localparam int NODE_W   = 8;
    localparam int WEIGHT_W = 64;
    localparam int ADDR_W   = (EDGE_MAX > 1) ? $clog2(EDGE_MAX) : 1;
    localparam int CNT_W    = $clog2(EDGE_MAX + 1);

    localparam logic [CNT_W-1:0]  EDGE_LIMIT = CNT_W'(EDGE_MAX);
    localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(NODE_MAX);

    localparam logic [2:0] CMD_SET_COUNT = 3'd0;
    localparam logic [2:0] CMD_ADD       = 3'd1;
    localparam logic [2:0] CMD_REMOVE    = 3'd2;
    localparam logic [2:0] CMD_HAS       = 3'd3;
    localparam logic [2:0] CMD_LIST      = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_RANGE = 3'd1;
    localparam logic [2:0] STAT_LOOP  = 3'd2;
    localparam logic [2:0] STAT_DUP   = 3'd3;
    localparam logic [2:0] STAT_FULL  = 3'd4;
    localparam logic [2:0] STAT_NONE  = 3'd5;

    typedef struct packed {
        logic [2:0]          command;
        logic [NODE_W-1:0]   source_node;
        logic [NODE_W-1:0]   target_node;
        logic [WEIGHT_W-1:0] edge_weight_in;
        logic [NODE_W-1:0]   new_node_count;
    } det_req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic                found;
        logic [NODE_W-1:0]   edge_source;
        logic [NODE_W-1:0]   edge_target;
        logic [WEIGHT_W-1:0] edge_weight_out;
        logic                last;
    } det_rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   tgt;
        logic [WEIGHT_W-1:0] wgt;
    } det_entry_t;

    localparam int ENTRY_W = $bits(det_entry_t);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } det_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
    } det_stat_t;

    function automatic logic node_ok(input logic [NODE_W-1:0] v,
                                     input logic [NODE_W-1:0] n);
        return (v != '0) && (v <= n);
    endfunction

endpackage

// ===== hdl/det_ram.sv =====
module det_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/det_ctrl.sv =====
module det_ctrl
    import det_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  det_stat_t stat,
    output det_ctrl_t ctrl,
    output logic      busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/det_dp.sv =====
module det_dp
    import det_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  det_ctrl_t ctrl,
    output det_stat_t stat,
    input  det_req_t  request,
    output det_rsp_t  result,
    output logic      result_valid
);

    // Command registers
    logic [2:0]          cmd_reg;
    logic [NODE_W-1:0]   src_reg;
    logic [NODE_W-1:0]   tgt_reg;
    logic [WEIGHT_W-1:0] wgt_reg;

    // Table state
    logic [NODE_W-1:0] node_count_reg, node_count_next;
    logic [CNT_W-1:0]  edge_count_reg, edge_count_next;

    // Scan engine
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             hold_valid_reg, hold_valid_next;
    det_entry_t       hold_reg, hold_next;

    // Result register
    det_rsp_t result_reg, result_next;
    logic     result_valid_reg, result_valid_next;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    det_entry_t        ram_wdata;
    logic              ram_re;
    det_entry_t        rd_entry;

    logic add_bad;
    logic scan_cmd;
    logic stop;
    logic issue;
    logic match_pair;
    logic keep;

    det_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EDGE_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg[ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    always_comb
    begin
        add_bad = !node_ok(src_reg, node_count_reg) || !node_ok(tgt_reg, node_count_reg)
                  || (src_reg == tgt_reg);

        unique case (cmd_reg) inside
            CMD_SET_COUNT, CMD_REMOVE, CMD_HAS, CMD_LIST: scan_cmd = 1'b1;
            CMD_ADD:                                      scan_cmd = !add_bad;
            default:                                      scan_cmd = 1'b0;
        endcase

        stop  = hit_reg && ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_HAS));
        issue = ctrl.scan && scan_cmd && !stop && (rd_ptr_reg < edge_count_reg);
        stat.scan_done = !pend_reg && !issue;

        match_pair = (rd_entry.src == src_reg) && (rd_entry.tgt == tgt_reg);
        keep       = 1'b0;

        node_count_next   = node_count_reg;
        edge_count_next   = edge_count_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        pend_next         = issue;
        hit_next          = hit_reg;
        hold_valid_next   = hold_valid_reg;
        hold_next         = hold_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = wr_ptr_reg[ADDR_W-1:0];
        ram_wdata         = rd_entry;
        ram_re            = issue;

        if (ctrl.load)
        begin
            rd_ptr_next     = '0;
            wr_ptr_next     = '0;
            hit_next        = 1'b0;
            hold_valid_next = 1'b0;
            if (request.command == CMD_SET_COUNT)
            begin
                node_count_next = (request.new_node_count > NODE_LIMIT) ? NODE_LIMIT
                                  : request.new_node_count;
            end
        end

        if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end

        // Evaluate the entry read in the previous cycle
        if (pend_reg)
        begin
            unique case (cmd_reg) inside
                CMD_SET_COUNT:
                begin
                    keep = node_ok(rd_entry.src, node_count_reg)
                           && node_ok(rd_entry.tgt, node_count_reg);
                end
                CMD_REMOVE:
                begin
                    keep = !(match_pair && !hit_reg);
                    if (match_pair)
                    begin
                        hit_next = 1'b1;
                    end
                end
                CMD_ADD, CMD_HAS:
                begin
                    if (match_pair)
                    begin
                        hit_next = 1'b1;
                    end
                end
                CMD_LIST:
                begin
                    if (rd_entry.src == src_reg)
                    begin
                        // Send the held match; the new one may be the last
                        if (hold_valid_reg)
                        begin
                            result_next       = {STAT_OK, 1'b1, hold_reg.src, hold_reg.tgt,
                                                 hold_reg.wgt, 1'b0};
                            result_valid_next = 1'b1;
                        end
                        hold_next       = rd_entry;
                        hold_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    keep = 1'b0;
                end
            endcase

            if (keep)
            begin
                ram_we      = 1'b1;
                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
            end
        end

        if (ctrl.finish)
        begin
            result_valid_next = 1'b1;
            result_next       = '0;
            result_next.last  = 1'b1;
            result_next.status = STAT_OK;
            unique case (cmd_reg)
                CMD_SET_COUNT:
                begin
                    edge_count_next = wr_ptr_reg;
                end
                CMD_ADD:
                begin
                    if (!node_ok(src_reg, node_count_reg) || !node_ok(tgt_reg, node_count_reg))
                    begin
                        result_next.status = STAT_RANGE;
                    end
                    else if (src_reg == tgt_reg)
                    begin
                        result_next.status = STAT_LOOP;
                    end
                    else if (hit_reg)
                    begin
                        result_next.status = STAT_DUP;
                    end
                    else if (edge_count_reg >= EDGE_LIMIT)
                    begin
                        result_next.status = STAT_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = edge_count_reg[ADDR_W-1:0];
                        ram_wdata       = {src_reg, tgt_reg, wgt_reg};
                        edge_count_next = edge_count_reg + CNT_W'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    edge_count_next = wr_ptr_reg;
                    if (!hit_reg)
                    begin
                        result_next.status = STAT_NONE;
                    end
                end
                CMD_HAS:
                begin
                    result_next.found = hit_reg;
                    if (!hit_reg)
                    begin
                        result_next.status = STAT_NONE;
                    end
                end
                CMD_LIST:
                begin
                    if (hold_valid_reg)
                    begin
                        result_next = {STAT_OK, 1'b1, hold_reg.src, hold_reg.tgt,
                                       hold_reg.wgt, 1'b1};
                    end
                    else
                    begin
                        result_next.status = STAT_NONE;
                    end
                end
                CMD_CLEAR:
                begin
                    edge_count_next = '0;
                    node_count_next = '0;
                end
                default:
                begin
                    result_next.status = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= request.command;
            src_reg <= request.source_node;
            tgt_reg <= request.target_node;
            wgt_reg <= request.edge_weight_in;
        end
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= '0;
            edge_count_reg   <= '0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            pend_reg         <= 1'b0;
            hit_reg          <= 1'b0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            node_count_reg   <= node_count_next;
            edge_count_reg   <= edge_count_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            pend_reg         <= pend_next;
            hit_reg          <= hit_next;
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== hdl/directed_edge_table.sv =====
// Ordered table of directed weighted edges over nodes 1..node count.
//
// Command channel: drive request and raise start; the command transfers at
// the rising edge where start is high and busy is low. Busy stays high until
// the command has finished its pass over the table.
// Result channel: each result is on result for one cycle with result_valid
// high; the receiver cannot stall it. Every command yields one result with
// last set, except list, which streams one result per matching edge in table
// order (last on the final one) or a single not-found result.
//
// Timing: a command walks the stored edges through the table RAM's read port,
// one entry per cycle. No entry is read for an empty table, clear, unused
// codes or an add rejected on its node checks; add and has stop early on a
// match. The final result is strobed in the first cycle with busy low and
// may overlap the next transfer. Set node count and remove compact the table
// in the same pass.
//
// Reset: edge count and node count go to zero; the RAM is not cleared, and
// only entries below the edge count are ever read.
module directed_edge_table
    import det_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  det_req_t request,
    output det_rsp_t result,
    output logic     result_valid
);

    det_ctrl_t ctrl;
    det_stat_t stat;

    // Sequence load, scan and finish
    det_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Table RAM, scan pointers, counts and result register
    det_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== bench/directed_edge_table_test.sv =====
`timescale 1ns / 100ps

module directed_edge_table_test
    import det_pkg::*;
();

    // Codes six and seven have no meaning; the block answers them with a bare ok.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 150;
    localparam int FILL_AT       = 70;   // random item index where the full-table run goes in
    localparam int PAUSE_AT      = 40;   // random item index where the sender drains the block
    localparam int CALM_TAIL     = 40;   // last random items sent back to back
    localparam int FILL_NODES    = 9;    // 72 possible edges, enough to fill the table
    localparam int DRAIN_CYCLES  = EDGE_MAX + 8;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct {
        det_req_t cmd;
        bit       typed;
        det_rsp_t want;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    det_req_t request;
    det_rsp_t result;
    logic     result_valid;

    // Shadow copy of the edge table, updated at each accepted transfer.
    det_entry_t edge_table [EDGE_MAX];
    int         stored_edges;
    logic [7:0] node_total;

    det_rsp_t   fresh_results[$];     // results of the command just modeled
    det_rsp_t   expected_results[$];  // results still owed by the block
    stim_row_t  directed [DIRECTED_ROWS];
    int         mismatch_total;
    int         cycle_count = 0;

    directed_edge_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs or drops a result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Edge table model
    //------------------------------------------------------------------

    function automatic bit node_valid(input logic [7:0] v);
        return (v >= 8'd1) && (v <= node_total);
    endfunction

    function automatic int edge_index(input logic [7:0] s, input logic [7:0] t);
        for (int i = 0; i < stored_edges; i++)
            if (edge_table[i].src == s && edge_table[i].tgt == t)
                return i;
        return -1;
    endfunction

    function automatic det_rsp_t plain_reply(input logic [2:0] st, input logic fnd);
        det_rsp_t r;
        r        = '0;
        r.status = st;
        r.found  = fnd;
        r.last   = 1'b1;
        return r;
    endfunction

    // Work out every result of one command and advance the shadow table.
    task automatic model_command(input det_req_t cmd);
        int       keep;
        int       idx;
        det_rsp_t r;
        fresh_results.delete();
        case (cmd.command)
            CMD_SET_COUNT:
            begin
                node_total = (cmd.new_node_count > NODE_MAX) ? NODE_LIMIT
                                                             : cmd.new_node_count;
                // Compact in place, holding the order of the survivors.
                keep = 0;
                for (int i = 0; i < stored_edges; i++)
                    if (node_valid(edge_table[i].src) && node_valid(edge_table[i].tgt))
                    begin
                        edge_table[keep] = edge_table[i];
                        keep++;
                    end
                stored_edges = keep;
                fresh_results.push_back(plain_reply(STAT_OK, 1'b0));
            end
            CMD_ADD:
            begin
                if (!node_valid(cmd.source_node) || !node_valid(cmd.target_node))
                    fresh_results.push_back(plain_reply(STAT_RANGE, 1'b0));
                else if (cmd.source_node == cmd.target_node)
                    fresh_results.push_back(plain_reply(STAT_LOOP, 1'b0));
                else if (edge_index(cmd.source_node, cmd.target_node) >= 0)
                    fresh_results.push_back(plain_reply(STAT_DUP, 1'b0));
                else if (stored_edges >= EDGE_MAX)
                    fresh_results.push_back(plain_reply(STAT_FULL, 1'b0));
                else
                begin
                    edge_table[stored_edges].src = cmd.source_node;
                    edge_table[stored_edges].tgt = cmd.target_node;
                    edge_table[stored_edges].wgt = cmd.edge_weight_in;
                    stored_edges++;
                    fresh_results.push_back(plain_reply(STAT_OK, 1'b0));
                end
            end
            CMD_REMOVE:
            begin
                idx = edge_index(cmd.source_node, cmd.target_node);
                if (idx < 0)
                    fresh_results.push_back(plain_reply(STAT_NONE, 1'b0));
                else
                begin
                    for (int i = idx; i + 1 < stored_edges; i++)
                        edge_table[i] = edge_table[i + 1];
                    stored_edges--;
                    fresh_results.push_back(plain_reply(STAT_OK, 1'b0));
                end
            end
            CMD_HAS:
            begin
                if (edge_index(cmd.source_node, cmd.target_node) >= 0)
                    fresh_results.push_back(plain_reply(STAT_OK, 1'b1));
                else
                    fresh_results.push_back(plain_reply(STAT_NONE, 1'b0));
            end
            CMD_LIST:
            begin
                for (int i = 0; i < stored_edges; i++)
                    if (edge_table[i].src == cmd.source_node)
                    begin
                        r                 = '0;
                        r.status          = STAT_OK;
                        r.found           = 1'b1;
                        r.edge_source     = edge_table[i].src;
                        r.edge_target     = edge_table[i].tgt;
                        r.edge_weight_out = edge_table[i].wgt;
                        fresh_results.push_back(r);
                    end
                if (fresh_results.size() == 0)
                    fresh_results.push_back(plain_reply(STAT_NONE, 1'b0));
                else
                    fresh_results[fresh_results.size() - 1].last = 1'b1;
            end
            CMD_CLEAR:
            begin
                stored_edges = 0;
                node_total   = '0;
                fresh_results.push_back(plain_reply(STAT_OK, 1'b0));
            end
            default:
                fresh_results.push_back(plain_reply(STAT_OK, 1'b0));
        endcase
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic stim_row_t make_row(input logic [2:0] op, input logic [7:0] s,
                                           input logic [7:0] t, input logic [63:0] w,
                                           input logic [7:0] n, input bit typed,
                                           input logic [2:0] st, input logic fnd);
        stim_row_t row;
        row.cmd.command        = op;
        row.cmd.source_node    = s;
        row.cmd.target_node    = t;
        row.cmd.edge_weight_in = w;
        row.cmd.new_node_count = n;
        row.typed              = typed;
        row.want               = plain_reply(st, fnd);
        return row;
    endfunction

    function automatic logic [63:0] random_weight();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] random_node();
        return 8'($urandom_range(0, 255));
    endfunction

    // A node inside the current range where there is one, else anything.
    function automatic logic [7:0] node_in_range();
        if (node_total == 8'd0)
            return random_node();
        return 8'($urandom_range(1, node_total));
    endfunction

    // Find a legal edge not yet stored, starting the scan at a random pair.
    function automatic bit find_absent(output logic [7:0] s, output logic [7:0] t);
        int span;
        int offset;
        int k;
        span   = node_total * node_total;
        s      = '0;
        t      = '0;
        if (span == 0)
            return 1'b0;
        offset = $urandom_range(0, span - 1);
        for (int i = 0; i < span; i++)
        begin
            k = (offset + i) % span;
            s = 8'(k / node_total + 1);
            t = 8'(k % node_total + 1);
            if (s != t && edge_index(s, t) < 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly well-formed commands against the current table, some noise.
    function automatic det_req_t random_command();
        det_req_t cmd;
        int       roll;
        int       pick;
        cmd.command        = CMD_SET_COUNT;
        cmd.source_node    = random_node();
        cmd.target_node    = random_node();
        cmd.edge_weight_in = random_weight();
        cmd.new_node_count = random_node();
        roll               = $urandom_range(0, 99);
        // With no nodes, almost nothing gets past the range check: set a count first.
        if (node_total == 8'd0 && $urandom_range(0, 9) < 7)
            roll = 0;
        if (roll < 8)
        begin
            cmd.command = CMD_SET_COUNT;
            case ($urandom_range(0, 9))
                0:       cmd.new_node_count = 8'd0;
                1:       cmd.new_node_count = 8'd255;
                2:       cmd.new_node_count = NODE_LIMIT;
                3:       cmd.new_node_count = NODE_LIMIT + 8'd1;
                4:       cmd.new_node_count = node_total - 8'd1;
                default: cmd.new_node_count = 8'($urandom_range(2, 12));
            endcase
        end
        else if (roll < 40)
        begin
            cmd.command = CMD_ADD;
            if ($urandom_range(0, 5) != 0)
            begin
                cmd.source_node = node_in_range();
                cmd.target_node = node_in_range();
            end
        end
        else if (roll < 70)
        begin
            cmd.command = (roll < 55) ? CMD_REMOVE : CMD_HAS;
            if (stored_edges > 0 && $urandom_range(0, 9) < 7)
            begin
                pick            = $urandom_range(0, stored_edges - 1);
                cmd.source_node = edge_table[pick].src;
                cmd.target_node = edge_table[pick].tgt;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                cmd.source_node = node_in_range();
                cmd.target_node = node_in_range();
            end
        end
        else if (roll < 92)
        begin
            cmd.command = CMD_LIST;
            if (stored_edges > 0 && $urandom_range(0, 3) != 0)
                cmd.source_node = edge_table[$urandom_range(0, stored_edges - 1)].src;
            else if ($urandom_range(0, 1) == 0)
                cmd.source_node = node_in_range();
        end
        else if (roll < 96)
            cmd.command = CMD_CLEAR;
        else
            cmd.command = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        return cmd;
    endfunction

    //------------------------------------------------------------------
    // Driver
    //------------------------------------------------------------------

    // Raise start with the command and hold it until the block takes the
    // transfer; start is left high so the next command can follow at once.
    task automatic send_command(input det_req_t cmd, input bit typed,
                                input det_rsp_t want);
        start   <= 1'b1;
        request <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model_command(cmd);
        if (typed)
        begin
            if (fresh_results.size() != 1)
                $display("%0t: typed row yields %0d results", $time, fresh_results.size());
            fresh_results.delete();
            fresh_results.push_back(want);
        end
        foreach (fresh_results[i])
            expected_results.push_back(fresh_results[i]);
    endtask

    task automatic send_modeled(input det_req_t cmd);
        send_command(cmd, PREDICTED, '0);
    endtask

    // Drop start for a random burst, or not at all when calm.
    task automatic idle_gap(input bit calm);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Push the table to its limit, knock on the full table, then shrink the
    // node range so one pass drops a large share of the entries.
    task automatic fill_table(input bit calm);
        det_req_t cmd;
        int       tries;
        cmd                = '0;
        cmd.command        = CMD_SET_COUNT;
        cmd.new_node_count = 8'(FILL_NODES);
        send_modeled(cmd);
        idle_gap(calm);
        tries = 0;
        while (stored_edges < EDGE_MAX && tries < 400)
        begin
            cmd                = random_command();
            cmd.command        = CMD_ADD;
            cmd.source_node    = node_in_range();
            cmd.target_node    = node_in_range();
            if ($urandom_range(0, 4) != 0)
                void'(find_absent(cmd.source_node, cmd.target_node));
            send_modeled(cmd);
            idle_gap(calm);
            tries++;
        end
        repeat (3)
        begin
            cmd         = random_command();
            cmd.command = CMD_ADD;
            void'(find_absent(cmd.source_node, cmd.target_node));
            send_modeled(cmd);
            idle_gap(calm);
        end
        repeat (3)
        begin
            cmd             = random_command();
            cmd.command     = CMD_LIST;
            cmd.source_node = node_in_range();
            send_modeled(cmd);
            idle_gap(calm);
        end
        cmd                = random_command();
        cmd.command        = CMD_SET_COUNT;
        cmd.new_node_count = 8'(FILL_NODES - 3);
        send_modeled(cmd);
        idle_gap(calm);
    endtask

    initial
    begin
        bit calm;

        // Extremes, every command and every status code apart from full.
        directed[0]  = make_row(CMD_LIST, 8'd1, 8'd0, '0, 8'd0, TYPED, STAT_NONE, 1'b0);
        directed[1]  = make_row(CMD_HAS, 8'd1, 8'd2, '0, 8'd0, TYPED, STAT_NONE, 1'b0);
        directed[2]  = make_row(CMD_ADD, 8'd1, 8'd2, '1, 8'd0, TYPED, STAT_RANGE, 1'b0);
        directed[3]  = make_row(CMD_SET_COUNT, 8'd0, 8'd0, '0, 8'd255, TYPED, STAT_OK, 1'b0);
        directed[4]  = make_row(CMD_ADD, 8'd0, 8'd5, '0, 8'd0, TYPED, STAT_RANGE, 1'b0);
        directed[5]  = make_row(CMD_ADD, 8'd64, 8'd65, '0, 8'd0, TYPED, STAT_RANGE, 1'b0);
        directed[6]  = make_row(CMD_ADD, 8'd3, 8'd3, '0, 8'd0, TYPED, STAT_LOOP, 1'b0);
        directed[7]  = make_row(CMD_ADD, 8'd1, 8'd64, '1, 8'd0, TYPED, STAT_OK, 1'b0);
        directed[8]  = make_row(CMD_ADD, 8'd1, 8'd64, '0, 8'd0, TYPED, STAT_DUP, 1'b0);
        directed[9]  = make_row(CMD_ADD, 8'd64, 8'd1, '0, 8'd0, TYPED, STAT_OK, 1'b0);
        directed[10] = make_row(CMD_ADD, 8'd1, 8'd2, 64'h5555_5555_5555_5555, 8'd0,
                                TYPED, STAT_OK, 1'b0);
        directed[11] = make_row(CMD_ADD, 8'd2, 8'd3, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0,
                                TYPED, STAT_OK, 1'b0);
        directed[12] = make_row(CMD_HAS, 8'd1, 8'd64, '0, 8'd0, TYPED, STAT_OK, 1'b1);
        directed[13] = make_row(CMD_HAS, 8'd64, 8'd2, '0, 8'd0, TYPED, STAT_NONE, 1'b0);
        directed[14] = make_row(CMD_LIST, 8'd1, 8'd0, '0, 8'd0, PREDICTED, STAT_OK, 1'b0);
        directed[15] = make_row(CMD_LIST, 8'd0, 8'd0, '0, 8'd0, TYPED, STAT_NONE, 1'b0);
        directed[16] = make_row(CMD_LIST, 8'd255, 8'd0, '0, 8'd0, TYPED, STAT_NONE, 1'b0);
        directed[17] = make_row(CMD_REMOVE, 8'd1, 8'd64, '0, 8'd0, TYPED, STAT_OK, 1'b0);
        directed[18] = make_row(CMD_REMOVE, 8'd1, 8'd64, '0, 8'd0, TYPED, STAT_NONE, 1'b0);
        // Shrinking to two nodes drops the head and the tail of the table.
        directed[19] = make_row(CMD_SET_COUNT, 8'd0, 8'd0, '0, 8'd2, TYPED, STAT_OK, 1'b0);
        directed[20] = make_row(CMD_LIST, 8'd1, 8'd0, '0, 8'd0, PREDICTED, STAT_OK, 1'b0);
        directed[21] = make_row(CMD_SPARE_6, 8'd255, 8'd255, '1, 8'd255,
                                TYPED, STAT_OK, 1'b0);
        directed[22] = make_row(CMD_SPARE_7, 8'd255, 8'd255, '1, 8'd255,
                                TYPED, STAT_OK, 1'b0);
        directed[23] = make_row(CMD_CLEAR, 8'd0, 8'd0, '0, 8'd0, TYPED, STAT_OK, 1'b0);
        directed[24] = make_row(CMD_LIST, 8'd1, 8'd0, '0, 8'd0, TYPED, STAT_NONE, 1'b0);

        stored_edges   = 0;
        node_total     = '0;
        mismatch_total = 0;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        request        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_command(directed[i].cmd, directed[i].typed, directed[i].want);
            idle_gap(1'b0);
        end

        calm = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Switch between bursty and back-to-back stretches now and then.
            if (i % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i >= RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            if (i == FILL_AT)
                fill_table(calm);
            send_modeled(random_command());
            if (i == PAUSE_AT)
            begin
                // Hold off until the block has delivered everything it owes.
                start <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            else
                idle_gap(calm);
        end
        start <= 1'b0;

        // Advance until every result is in, then watch for strays.
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_total == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    //------------------------------------------------------------------
    // Result checker: every strobed result is taken against the oldest
    // outstanding expectation.
    //------------------------------------------------------------------

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        det_rsp_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, got %h", $time, result);
                mismatch_total++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(result.status));
                check_field("found", 64'(want.found), 64'(result.found));
                check_field("edge_source", 64'(want.edge_source), 64'(result.edge_source));
                check_field("edge_target", 64'(want.edge_target), 64'(result.edge_target));
                check_field("edge_weight_out", want.edge_weight_out, result.edge_weight_out);
                check_field("last", 64'(want.last), 64'(result.last));
            end
        end
    end

endmodule
